/* src/lbc_pkg.sv */
package lbc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_BITS       = 24;

  localparam int RESET_LEFT   = 0;
  localparam int RESET_RIGHT  = 1023;
  localparam int RESET_TOP    = 0;
  localparam int RESET_BOTTOM = 1023;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  // per-edge outcome of the setup stage
  typedef struct packed {
    logic active;  // edge contributes a quotient
    logic enter;   // quotient is an entering ratio
    logic rej;     // edge alone rejects the segment
  } edge_flags_t;

endpackage

/* src/lbc_setup.sv */
module lbc_setup #(
  parameter int COORD_BITS = lbc_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [COORD_BITS-1:0]             win_left,
  input  logic signed [COORD_BITS-1:0]             win_right,
  input  logic signed [COORD_BITS-1:0]             win_top,
  input  logic signed [COORD_BITS-1:0]             win_bottom,
  input  logic signed [COORD_BITS-1:0]             x0,
  input  logic signed [COORD_BITS-1:0]             y0,
  input  logic signed [COORD_BITS-1:0]             x1,
  input  logic signed [COORD_BITS-1:0]             y1,
  output logic        [3:0][COORD_BITS-1:0]        num_r,
  output logic        [3:0][COORD_BITS-1:0]        den_r,
  output lbc_pkg::edge_flags_t [3:0]               flags_r,
  output logic signed [COORD_BITS-1:0]             x0_r,
  output logic signed [COORD_BITS-1:0]             y0_r,
  output logic signed [COORD_BITS:0]               dx_r,
  output logic signed [COORD_BITS:0]               dy_r
);

  localparam int EW = COORD_BITS + 2;

  logic signed [EW-1:0]         dx, dy;
  logic signed [EW-1:0]         p   [4];
  logic signed [EW-1:0]         q   [4];
  logic [3:0][COORD_BITS-1:0]   num_nxt, den_nxt;
  lbc_pkg::edge_flags_t [3:0]   flags_nxt;

  assign dx = EW'(x1) - EW'(x0);
  assign dy = EW'(y1) - EW'(y0);

  always_comb begin
    p[0] = -dx;  q[0] = EW'(x0) - EW'(win_left);
    p[1] = dx;   q[1] = EW'(win_right) - EW'(x0);
    p[2] = -dy;  q[2] = EW'(y0) - EW'(win_top);
    p[3] = dy;   q[3] = EW'(win_bottom) - EW'(y0);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num_nxt[i]   = '0;
      den_nxt[i]   = COORD_BITS'(1);
      flags_nxt[i] = '0;
      if (p[i] == '0) begin
        flags_nxt[i].rej = q[i] < 0;
      end else if (p[i] < 0) begin
        // entering edge: ratio (-q)/(-p)
        if (-q[i] <= 0) begin
          flags_nxt[i].active = 1'b0;
        end else if (-q[i] > -p[i]) begin
          flags_nxt[i].rej = 1'b1;
        end else begin
          flags_nxt[i].active = 1'b1;
          flags_nxt[i].enter  = 1'b1;
          num_nxt[i] = COORD_BITS'(-q[i]);
          den_nxt[i] = COORD_BITS'(-p[i]);
        end
      end else begin
        // leaving edge: ratio q/p, q >= p saturates to one (no effect)
        if (q[i] < 0) begin
          flags_nxt[i].rej = 1'b1;
        end else if (q[i] < p[i]) begin
          flags_nxt[i].active = 1'b1;
          num_nxt[i] = COORD_BITS'(q[i]);
          den_nxt[i] = COORD_BITS'(p[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num_nxt;
      den_r   <= den_nxt;
      flags_r <= flags_nxt;
      x0_r    <= x0;
      y0_r    <= y0;
      dx_r    <= (COORD_BITS+1)'(dx);
      dy_r    <= (COORD_BITS+1)'(dy);
    end
  end

endmodule

/* src/lbc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Requires 0 <= num <= den, den != 0; gives floor(num * 2^FRAC_BITS / den).
module lbc_div #(
  parameter int COORD_BITS = lbc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] num,
  input  logic [COORD_BITS-1:0] den,
  output logic [FRAC_BITS:0]    quo
);

  logic [FRAC_BITS:0]    quo_r [FRAC_BITS+1];
  logic [COORD_BITS-1:0] rem_r [FRAC_BITS+1];
  logic [COORD_BITS-1:0] den_r [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r[0] <= (FRAC_BITS+1)'(num >= den);
      rem_r[0] <= (num >= den) ? num - den : num;
      den_r[0] <= den;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
    logic [COORD_BITS:0] rem2;
    logic                ge;
    assign rem2 = {rem_r[k-1], 1'b0};
    assign ge   = rem2 >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_r[k-1][FRAC_BITS-1:0], ge};
        rem_r[k] <= ge ? COORD_BITS'(rem2 - {1'b0, den_r[k-1]}) : COORD_BITS'(rem2);
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo = quo_r[FRAC_BITS];

endmodule

/* src/lbc_point.sv */
// c*256 + round(d*u / 2^(FRAC_BITS-8)), saturated, or zero when vis is low; two register stages.
module lbc_point #(
  parameter int COORD_BITS = lbc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                vis,
  input  logic signed [COORD_BITS-1:0]        c,
  input  logic signed [COORD_BITS:0]          d,
  input  logic        [FRAC_BITS:0]           u,
  output logic signed [lbc_pkg::OUT_BITS-1:0] coord_r
);

  localparam int OB = lbc_pkg::OUT_BITS;
  localparam int PW = COORD_BITS + FRAC_BITS + 3;
  localparam int VW = (PW + 1 > OB + 1) ? PW + 1 : OB + 1;
  localparam int S  = FRAC_BITS - 8;
  localparam logic signed [PW-1:0] RND = PW'((1 << S) >> 1);
  localparam logic signed [VW-1:0] HI  = VW'((1 << (OB - 1)) - 1);
  localparam logic signed [VW-1:0] LO  = -HI - VW'(1);

  logic signed [PW-1:0]         prod_r;
  logic signed [COORD_BITS-1:0] c_r;
  logic                         vis_r;
  logic signed [PW-1:0]         t;
  logic signed [VW-1:0]         v;
  logic signed [OB-1:0]         coord_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(d * $signed({1'b0, u}));
      c_r    <= c;
      vis_r  <= vis;
    end
  end

  always_comb begin
    t = prod_r + RND;
    v = (VW'(c_r) <<< 8) + VW'(t >>> S);
    if (!vis_r) begin
      coord_nxt = '0;
    end else if (v > HI) begin
      coord_nxt = HI[OB-1:0];
    end else if (v < LO) begin
      coord_nxt = LO[OB-1:0];
    end else begin
      coord_nxt = v[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
    end
  end

endmodule

/* src/liang_barsky_line_clip.sv */
// Channel   Dir  Handshake            Payload
// in_       in   in_valid/in_ready    start_x, start_y, end_x, end_y (signed)
// out_      out  out_valid/out_ready  visible, clip_{start,end}_{x,y} (Q16.8)
// cfg_      in   cfg_we               cfg_index, cfg_wdata (window edges)
//
// One transfer per cycle in and out while the output is not stalled. A segment passes
// the setup register, the bit-per-stage quotient pipeline (FRAC_BITS+1 stages),
// then the combine, multiply and output registers.
// rst_n (sync, active low) clears valid bits and restores the default window.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
module liang_barsky_line_clip #(
  parameter int COORD_BITS = lbc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // segment input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_start_x,
  input  logic signed [COORD_BITS-1:0]        in_start_y,
  input  logic signed [COORD_BITS-1:0]        in_end_x,
  input  logic signed [COORD_BITS-1:0]        in_end_y,
  // clipped result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_visible,
  output logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_start_x,
  output logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_start_y,
  output logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_end_x,
  output logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_end_y,
  // window registers
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_wdata
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // data that rides alongside the quotient pipeline
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    lbc_pkg::edge_flags_t [3:0]   flags;
  } side_t;

  logic signed [COORD_BITS-1:0] left_r, right_r, top_r, bottom_r;

  logic adv;  // whole pipeline advances
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= COORD_BITS'(lbc_pkg::RESET_LEFT);
      right_r  <= COORD_BITS'(lbc_pkg::RESET_RIGHT);
      top_r    <= COORD_BITS'(lbc_pkg::RESET_TOP);
      bottom_r <= COORD_BITS'(lbc_pkg::RESET_BOTTOM);
    end else if (cfg_we) begin
      unique case (lbc_pkg::reg_idx_t'(cfg_index))
        lbc_pkg::REG_LEFT:   left_r   <= cfg_wdata;
        lbc_pkg::REG_RIGHT:  right_r  <= cfg_wdata;
        lbc_pkg::REG_TOP:    top_r    <= cfg_wdata;
        lbc_pkg::REG_BOTTOM: bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- setup stage: deltas, edge (p,q) classification
  logic [3:0][COORD_BITS-1:0]   num_s, den_s;
  side_t                        side_s;
  logic                         v_setup_r;

  lbc_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk        (clk),
    .en         (adv),
    .win_left   (left_r),
    .win_right  (right_r),
    .win_top    (top_r),
    .win_bottom (bottom_r),
    .x0         (in_start_x),
    .y0         (in_start_y),
    .x1         (in_end_x),
    .y1         (in_end_y),
    .num_r      (num_s),
    .den_r      (den_s),
    .flags_r    (side_s.flags),
    .x0_r       (side_s.x0),
    .y0_r       (side_s.y0),
    .dx_r       (side_s.dx),
    .dy_r       (side_s.dy)
  );

  // ---- quotient pipeline, one divider per edge
  logic [FRAC_BITS:0] ratio [4];

  for (genvar e = 0; e < 4; e++) begin : g_div
    lbc_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num_s[e]),
      .den (den_s[e]),
      .quo (ratio[e])
    );
  end

  side_t side_r [FRAC_BITS+1];
  logic  [FRAC_BITS:0] v_div_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_s;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_setup_r <= 1'b0;
      v_div_r   <= '0;
    end else if (adv) begin
      v_setup_r <= in_valid;
      v_div_r   <= {v_div_r[FRAC_BITS-1:0], v_setup_r};
    end
  end

  // ---- combine: entry = max of entering, exit = min of leaving
  side_t              side_d;
  logic [FRAC_BITS:0] entry_nxt, exit_nxt;
  logic               vis_nxt;
  logic [FRAC_BITS:0] entry_r, exit_r;
  logic               vis_r, v_comb_r;
  side_t              side_c_r;

  assign side_d = side_r[FRAC_BITS];

  always_comb begin
    entry_nxt = '0;
    exit_nxt  = ONE;
    vis_nxt   = 1'b1;
    for (int e = 0; e < 4; e++) begin
      if (side_d.flags[e].rej) begin
        vis_nxt = 1'b0;
      end
      if (side_d.flags[e].active && side_d.flags[e].enter && ratio[e] > entry_nxt) begin
        entry_nxt = ratio[e];
      end
      if (side_d.flags[e].active && !side_d.flags[e].enter && ratio[e] < exit_nxt) begin
        exit_nxt = ratio[e];
      end
    end
    if (entry_nxt > exit_nxt) begin
      vis_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_r  <= entry_nxt;
      exit_r   <= exit_nxt;
      vis_r    <= vis_nxt;
      side_c_r <= side_d;
    end
  end

  // ---- endpoint multiply and round (two stages inside lbc_point)
  logic v_mul_r, out_valid_r, out_visible_r, vis_m_r;

  lbc_point #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sx (
    .clk (clk), .en (adv), .vis (vis_r), .c (side_c_r.x0), .d (side_c_r.dx),
    .u (entry_r), .coord_r (out_clip_start_x)
  );
  lbc_point #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sy (
    .clk (clk), .en (adv), .vis (vis_r), .c (side_c_r.y0), .d (side_c_r.dy),
    .u (entry_r), .coord_r (out_clip_start_y)
  );
  lbc_point #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ex (
    .clk (clk), .en (adv), .vis (vis_r), .c (side_c_r.x0), .d (side_c_r.dx),
    .u (exit_r), .coord_r (out_clip_end_x)
  );
  lbc_point #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ey (
    .clk (clk), .en (adv), .vis (vis_r), .c (side_c_r.y0), .d (side_c_r.dy),
    .u (exit_r), .coord_r (out_clip_end_y)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      vis_m_r       <= vis_r;
      out_visible_r <= vis_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_comb_r    <= 1'b0;
      v_mul_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_comb_r    <= v_div_r[FRAC_BITS];
      v_mul_r     <= v_comb_r;
      out_valid_r <= v_mul_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

/* src/lbc_checker.sv */
module lbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible,
  input logic [23:0] out_clip_start_x,
  input logic [23:0] out_clip_start_y,
  input logic [23:0] out_clip_end_x,
  input logic [23:0] out_clip_end_y
);

  // held result keeps valid, visible, clip start x and clip end y
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible)
      && $stable(out_clip_start_x) && $stable(out_clip_end_y))
    else $error("result changed while stalled");

  // rejected segment reports zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_clip_start_x == '0 && out_clip_start_y == '0
      && out_clip_end_x == '0 && out_clip_end_y == '0)
    else $error("rejected segment with nonzero coordinates");

  // input is taken whenever the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output slot");

  // a stall with a waiting result holds off the input side
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

endmodule

bind liang_barsky_line_clip lbc_checker u_lbc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_visible      (out_visible),
  .out_clip_start_x (out_clip_start_x),
  .out_clip_start_y (out_clip_start_y),
  .out_clip_end_x   (out_clip_end_x),
  .out_clip_end_y   (out_clip_end_y)
);

/* test/liang_barsky_line_clip_tb.sv */
`timescale 1ns / 1ps

module liang_barsky_line_clip_tb;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LATENCY = FB + 5;

  typedef struct packed {
    logic signed [CB-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct packed {
    logic vis;
    logic signed [lbc_pkg::OUT_BITS-1:0] csx, csy, cex, cey;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_start_x, out_clip_start_y;
  logic signed [lbc_pkg::OUT_BITS-1:0] out_clip_end_x, out_clip_end_y;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = lbc_pkg::REG_LEFT;
  logic [CB-1:0] cfg_wdata = '0;

  liang_barsky_line_clip dut (.*);

  always #5 clk = ~clk;

  // shadow window registers, updated with each config write
  longint win_l = lbc_pkg::RESET_LEFT, win_r = lbc_pkg::RESET_RIGHT;
  longint win_t = lbc_pkg::RESET_TOP, win_b = lbc_pkg::RESET_BOTTOM;

  segment_t  seg_q[$];
  clip_res_t clip_q[$];
  int  fails = 0;
  bit  idle_enable = 1'b0;   // random gaps on both sides
  int  hold_cycles = 0;      // receiver back-pressure stretch
  bit  hold_go = 1'b0;       // starts a back-pressure stretch

  // one edge of the clip test; entry/exit are Q1.FB
  function automatic void clip_edge(input longint p, input longint q,
                                    inout longint entry, inout longint exitv,
                                    inout bit rej);
    longint r;
    if (p == 0) begin
      if (q < 0) rej = 1;
    end else if (p < 0) begin
      if (-q <= 0) r = 0;
      else if (-q > -p) begin
        rej = 1;
        return;
      end else r = ((-q) <<< FB) / (-p);
      if (r > entry) entry = r;
    end else begin
      if (q < 0) begin
        rej = 1;
        return;
      end
      if (q >= p) r = longint'(1) <<< FB;
      else r = (q <<< FB) / p;
      if (r < exitv) exitv = r;
    end
  endfunction

  // Q16.8 endpoint: c + d*u, round half up, saturate to 24 bits
  function automatic logic [lbc_pkg::OUT_BITS-1:0] endpoint_q8(input longint c,
                                                              input longint d,
                                                              input longint u);
    longint t, v;
    t = d * u + (longint'(1) <<< (FB - 9));
    v = c * 256 + (t >>> (FB - 8));   // arithmetic shift floors
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[lbc_pkg::OUT_BITS-1:0];
  endfunction

  function automatic clip_res_t clip_segment(input segment_t s);
    longint x0, y0, dx, dy, entry, exitv;
    bit rej;
    clip_res_t r;
    x0 = s.sx; y0 = s.sy;
    dx = longint'(s.ex) - x0; dy = longint'(s.ey) - y0;
    entry = 0; exitv = longint'(1) <<< FB; rej = 0;
    clip_edge(-dx, x0 - win_l, entry, exitv, rej);
    clip_edge(dx, win_r - x0, entry, exitv, rej);
    clip_edge(-dy, y0 - win_t, entry, exitv, rej);
    clip_edge(dy, win_b - y0, entry, exitv, rej);
    if (entry > exitv) rej = 1;
    r = '0;
    if (!rej) begin
      r.vis = 1'b1;
      r.csx = endpoint_q8(x0, dx, entry);
      r.csy = endpoint_q8(y0, dy, entry);
      r.cex = endpoint_q8(x0, dx, exitv);
      r.cey = endpoint_q8(y0, dy, exitv);
    end
    return r;
  endfunction

  // driver: offers the next pending segment, keeps it steady until transfer
  always @(posedge clk) begin
    clip_res_t x;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        x = clip_segment(seg_q.pop_front());
        clip_q = {clip_q, x};
      end
      if (!in_valid || in_ready) begin
        // previous transfer done (or nothing offered): decide on the next
        if ((in_valid && in_ready ? seg_q.size() > 0 : seg_q.size() > 0) &&
            !(idle_enable && $urandom_range(99) < 26)) begin
          in_valid   <= 1'b1;
          in_start_x <= seg_q[0].sx;
          in_start_y <= seg_q[0].sy;
          in_end_x   <= seg_q[0].ex;
          in_end_y   <= seg_q[0].ey;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // back-pressure counter
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cycles <= 200;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    clip_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (clip_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = clip_q.pop_front();
          if (out_visible !== e.vis) begin
            $error("visible exp %0d got %0d", e.vis, out_visible); fails++;
          end
          if (out_clip_start_x !== e.csx) begin
            $error("clip_start_x exp %0d got %0d", e.csx, out_clip_start_x); fails++;
          end
          if (out_clip_start_y !== e.csy) begin
            $error("clip_start_y exp %0d got %0d", e.csy, out_clip_start_y); fails++;
          end
          if (out_clip_end_x !== e.cex) begin
            $error("clip_end_x exp %0d got %0d", e.cex, out_clip_end_x); fails++;
          end
          if (out_clip_end_y !== e.cey) begin
            $error("clip_end_y exp %0d got %0d", e.cey, out_clip_end_y); fails++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_enable && $urandom_range(99) < 26);
      end
    end
  end

  task automatic add_seg(input int sx, input int sy, input int ex, input int ey);
    segment_t s;
    s.sx = CB'(sx); s.sy = CB'(sy); s.ex = CB'(ex); s.ey = CB'(ey);
    seg_q = {seg_q, s};
  endtask

  // window write; only called with the pipeline drained
  task automatic write_window(input lbc_pkg::reg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CB-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lbc_pkg::REG_LEFT:   win_l = longint'($signed(val[CB-1:0]));
      lbc_pkg::REG_RIGHT:  win_r = longint'($signed(val[CB-1:0]));
      lbc_pkg::REG_TOP:    win_t = longint'($signed(val[CB-1:0]));
      lbc_pkg::REG_BOTTOM: win_b = longint'($signed(val[CB-1:0]));
      default: ;
    endcase
  endtask

  task automatic set_window(input int l, input int r, input int t, input int b);
    write_window(lbc_pkg::REG_LEFT, l);
    write_window(lbc_pkg::REG_RIGHT, r);
    write_window(lbc_pkg::REG_TOP, t);
    write_window(lbc_pkg::REG_BOTTOM, b);
  endtask

  task automatic drain();
    wait (seg_q.size() == 0 && !in_valid && clip_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // random segment; mostly near the window so clipping actually happens
  task automatic rand_seg();
    int sx, sy, ex, ey, m;
    m = $urandom_range(9);
    if (m < 2) begin
      sx = $signed(16'($urandom)); sy = $signed(16'($urandom));
      ex = $signed(16'($urandom)); ey = $signed(16'($urandom));
    end else begin
      sx = int'(win_l) - 200 + $urandom_range(1500);
      ex = int'(win_l) - 200 + $urandom_range(1500);
      sy = int'(win_t) - 200 + $urandom_range(1500);
      ey = int'(win_t) - 200 + $urandom_range(1500);
      if (m == 2) ex = sx;               // vertical
      if (m == 3) ey = sy;               // horizontal
      if (m == 4 && $urandom_range(3) == 0) begin
        ex = sx; ey = sy;                // point
      end
      sx = $signed(16'(sx)); sy = $signed(16'(sy));
      ex = $signed(16'(ex)); ey = $signed(16'(ey));
    end
    add_seg(sx, sy, ex, ey);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, default window 0..1023
    add_seg(10, 10, 500, 600);           // fully inside
    add_seg(-100, 500, 2000, 500);       // horizontal crossing both sides
    add_seg(500, -100, 500, 2000);       // vertical crossing top and bottom
    add_seg(-50, 20, -50, 900);          // parallel, outside left
    add_seg(1100, 20, 1100, 900);        // parallel, outside right
    add_seg(20, -5, 900, -5);            // parallel, above
    add_seg(20, 1030, 900, 1030);        // parallel, below
    add_seg(300, 300, 300, 300);         // point inside
    add_seg(0, 1023, 0, 1023);           // point on corner
    add_seg(-1, 5, -1, 5);               // point outside
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-32768, 0, -32768, 0);
    add_seg(32767, 32767, 32767, 32767);
    add_seg(-200, 100, 100, -200);       // misses corner, entry > exit
    add_seg(2000, 3, 1500, 7);           // entirely right, entering ratio > 1
    add_seg(1023, 0, 0, 1023);           // diagonal on corners
    add_seg(-7, -3, 1030, 1029);         // fractional clip points
    drain();

    // inverted window rejects everything
    set_window(500, 100, 0, 1023);
    add_seg(0, 10, 800, 10);
    add_seg(300, 300, 300, 300);
    drain();

    // extreme window; saturation of the Q16.8 outputs
    set_window(-32768, 32767, -32768, 32767);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, 32767, -32768, -32768);
    add_seg(12345, -32768, -1, 32767);
    drain();

    // random phases under several windows
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_window(lbc_pkg::RESET_LEFT, lbc_pkg::RESET_RIGHT,
                      lbc_pkg::RESET_TOP, lbc_pkg::RESET_BOTTOM);
        1: set_window(-300, 300, -200, 250);
        2: set_window(100, 101, 50, 50);
        3: set_window(-32768, 32767, -32768, 32767);
        default: set_window(-1000, 700, 20, 900);
      endcase
      idle_enable = (ph != 1);           // phase 1 runs at full rate
      for (int i = 0; i < 340; i++) rand_seg();
      if (ph == 2) begin
        // long receiver stall so the pipeline fills and in_ready drops
        wait (clip_q.size() > 5);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      drain();
    end

    if (fails == 0) $display("liang_barsky_line_clip regression: pass");
    else $display("liang_barsky_line_clip regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("liang_barsky_line_clip regression: fail");
    $finish;
  end

endmodule
